[src/tilt_ctf_defocus_adjust_assert.svh]
// Assertion macros for the tilt CTF defocus adjustment block.
`ifndef TILT_CTF_DEFOCUS_ADJUST_ASSERT_SVH
`define TILT_CTF_DEFOCUS_ADJUST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCDA_ASSERT_IMPL(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("tcda assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCDA_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("tcda assertion failed");

`endif

[src/tcda_pkg.sv]
// Types, constants and helper functions shared by the defocus adjustment modules.
`default_nettype none
package tcda_pkg;
	localparam int CordicSteps = 20;
	localparam int CxW = 33;
	localparam int CzW = 24;
	localparam logic signed [CxW-1:0] GainQ30 = 33'sd652032874;
	localparam logic [25:0] DfLimit = 26'h3FFFFFF;
	localparam logic signed [14:0] TiltLimit = 15'sd8500;
	localparam logic [15:0] TurnCd = 16'd36000;
	localparam int Div1Nw = 52;
	localparam int Div1Dw = 32;
	localparam int Div1Qw = 26;
	localparam int Div2Nw = 64;
	localparam int Div2Dw = 27;
	localparam int Div2Qw = 36;

	typedef struct packed {
		logic [7:0] img;
		logic [15:0] az;
		logic byp;
		logic signed [20:0] sx;
		logic signed [20:0] sy;
		logic [25:0] dmin;
		logic [25:0] dmax;
		logic [19:0] pix;
	} cs_side_t;

	typedef struct packed {
		logic [7:0] img;
		logic [15:0] az;
		logic byp;
		logic signed [30:0] xf;
		logic neg;
		logic [25:0] dmin;
		logic [25:0] dmax;
		logic [19:0] pix;
	} d1_side_t;

	typedef struct packed {
		logic [7:0] img;
		logic [15:0] az;
		logic byp;
		logic neg;
		logic [25:0] dmin;
		logic [25:0] dmax;
		logic signed [36:0] n;
	} d2_side_t;

	typedef struct packed {
		logic clamp;
		logic [25:0] val;
	} sat_t;

	// Arctangent of 2^-i in 1/256 centidegree.
	function automatic logic signed [CzW-1:0] atan_lut(input int i);
		logic signed [CzW-1:0] r;
		case (i)
			0: r = 24'sd1152000;
			1: r = 24'sd680065;
			2: r = 24'sd359328;
			3: r = 24'sd182400;
			4: r = 24'sd91554;
			5: r = 24'sd45822;
			6: r = 24'sd22916;
			7: r = 24'sd11459;
			8: r = 24'sd5730;
			9: r = 24'sd2865;
			10: r = 24'sd1432;
			11: r = 24'sd716;
			12: r = 24'sd358;
			13: r = 24'sd179;
			14: r = 24'sd90;
			15: r = 24'sd45;
			16: r = 24'sd22;
			17: r = 24'sd11;
			18: r = 24'sd6;
			19: r = 24'sd3;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic sat_t sat_df(input logic signed [38:0] v);
		sat_t r;
		if (v < 0) begin
			r.clamp = 1'b1;
			r.val = '0;
		end else if (v > $signed({13'd0, DfLimit})) begin
			r.clamp = 1'b1;
			r.val = DfLimit;
		end else begin
			r.clamp = 1'b0;
			r.val = v[25:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

[src/tcda_cordic.sv]
// Two-lane pipelined rotation CORDIC, one micro-rotation per stage.
`default_nettype none
module tcda_cordic import tcda_pkg::*; #(
	parameter int SW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input logic signed [CzW-1:0] z_axis,
	input logic signed [CzW-1:0] z_tilt,
	input logic flip_axis,
	input logic flip_tilt,
	input logic [SW-1:0] side_in,
	output logic out_v,
	output logic signed [CxW-1:0] cos_axis,
	output logic signed [CxW-1:0] sin_axis,
	output logic signed [CxW-1:0] cos_tilt,
	output logic signed [CxW-1:0] sin_tilt,
	output logic [SW-1:0] side_out
);
	logic signed [CxW-1:0] x_q [2][CordicSteps];
	logic signed [CxW-1:0] y_q [2][CordicSteps];
	logic signed [CzW-1:0] z_q [2][CordicSteps];
	logic f_q [2][CordicSteps];
	logic [SW-1:0] side_q [CordicSteps];
	logic v_q [CordicSteps];
	logic signed [CzW-1:0] z_init [2];
	logic f_init [2];

	assign z_init[0] = z_axis;
	assign z_init[1] = z_tilt;
	assign f_init[0] = flip_axis;
	assign f_init[1] = flip_tilt;

	for (genvar k = 0; k < CordicSteps; k++) begin : g_step
		logic v_i;
		logic [SW-1:0] side_i;
		if (k == 0) begin : g_first
			assign v_i = in_v;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i = v_q[k-1];
			assign side_i = side_q[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k] <= side_i;
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic signed [CxW-1:0] x_i;
			logic signed [CxW-1:0] y_i;
			logic signed [CzW-1:0] z_i;
			logic f_i;
			if (k == 0) begin : g_first
				assign x_i = GainQ30;
				assign y_i = '0;
				assign z_i = z_init[l];
				assign f_i = f_init[l];
			end else begin : g_next
				assign x_i = x_q[l][k-1];
				assign y_i = y_q[l][k-1];
				assign z_i = z_q[l][k-1];
				assign f_i = f_q[l][k-1];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					f_q[l][k] <= f_i;
					if (z_i >= 0) begin
						x_q[l][k] <= x_i - (y_i >>> k);
						y_q[l][k] <= y_i + (x_i >>> k);
						z_q[l][k] <= z_i - atan_lut(k);
					end else begin
						x_q[l][k] <= x_i + (y_i >>> k);
						y_q[l][k] <= y_i - (x_i >>> k);
						z_q[l][k] <= z_i + atan_lut(k);
					end
				end
			end
		end
	end

	assign out_v = v_q[CordicSteps-1];
	assign side_out = side_q[CordicSteps-1];
	assign cos_axis = f_q[0][CordicSteps-1] ? -x_q[0][CordicSteps-1] : x_q[0][CordicSteps-1];
	assign sin_axis = f_q[0][CordicSteps-1] ? -y_q[0][CordicSteps-1] : y_q[0][CordicSteps-1];
	assign cos_tilt = f_q[1][CordicSteps-1] ? -x_q[1][CordicSteps-1] : x_q[1][CordicSteps-1];
	assign sin_tilt = f_q[1][CordicSteps-1] ? -y_q[1][CordicSteps-1] : y_q[1][CordicSteps-1];
endmodule
`default_nettype wire

[src/tcda_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
`default_nettype none
module tcda_div import tcda_pkg::*; #(
	parameter int NW = 52,
	parameter int DW = 32,
	parameter int QW = 26,
	parameter int SW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	input logic [SW-1:0] side_in,
	output logic out_v,
	output logic [QW-1:0] quot,
	output logic [SW-1:0] side_out
);
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];
	logic [SW-1:0] side_q [QW];
	logic v_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [NW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QW-1:0] quo_i;
		logic [SW-1:0] side_i;
		logic v_i;
		logic [CW-1:0] trial;
		logic ge;
		if (k == 0) begin : g_first
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
			assign side_i = side_in;
			assign v_i = in_v;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign den_i = den_q[k-1];
			assign quo_i = quo_q[k-1];
			assign side_i = side_q[k-1];
			assign v_i = v_q[k-1];
		end
		assign trial = CW'(den_i) << (QW - 1 - k);
		assign ge = (CW'(rem_i) >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? NW'(CW'(rem_i) - trial) : rem_i;
				quo_q[k] <= quo_i | (QW'(ge) << (QW - 1 - k));
				den_q[k] <= den_i;
				side_q[k] <= side_i;
			end
		end
	end

	assign out_v = v_q[QW-1];
	assign quot = quo_q[QW-1];
	assign side_out = side_q[QW-1];
endmodule
`default_nettype wire

[src/tilt_ctf_defocus_adjust.sv]
// Top level of the tilt CTF defocus adjustment pipeline.
// An input passes through stage 1, the CORDIC, stages 22 and 23, the tangent divider, stages 24 to 29,
// the ratio divider and stage 30. One image enters per cycle while in_ready is high; the two CORDIC lanes and the two
// dividers are fully pipelined. All stages advance together and hold while the output waits for a transfer.
// Reset clears the stage valid bits only; no clearing pass is needed.
`default_nettype none
`include "tilt_ctf_defocus_adjust_assert.svh"
module tilt_ctf_defocus_adjust import tcda_pkg::*; #(
	parameter int MAX_IMAGES = 256
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] image_index,
	input logic signed [20:0] shift_x,
	input logic signed [20:0] shift_y,
	input logic signed [15:0] axis_angle,
	input logic signed [14:0] tilt_angle,
	input logic [15:0] azimuth_in,
	input logic [19:0] pixel_size,
	input logic [25:0] defocus_min_in,
	input logic [25:0] defocus_max_in,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] image_out,
	output logic [15:0] azimuth_out,
	output logic [25:0] defocus_min_out,
	output logic [25:0] defocus_max_out,
	output logic saturated
);
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: wraps, folds and the tilt clamp.
	logic signed [17:0] az_diff;
	logic signed [17:0] az_wrap;
	logic signed [16:0] ax_w;
	logic signed [16:0] ax_f;
	logic ax_flip;
	logic signed [14:0] tl_c;
	logic byp;
	logic v_s1;
	cs_side_t cs_s1;
	logic signed [CzW-1:0] zax_s1;
	logic signed [CzW-1:0] ztl_s1;
	logic fax_s1;

	assign az_diff = $signed({2'b00, azimuth_in}) - 18'(axis_angle);
	assign byp = (32'(image_index) >= 32'(MAX_IMAGES));

	always_comb begin
		if (az_diff < 0) begin
			az_wrap = az_diff + 18'sd36000;
		end else if (az_diff >= 18'sd72000) begin
			az_wrap = az_diff - 18'sd72000;
		end else if (az_diff >= 18'sd36000) begin
			az_wrap = az_diff - 18'sd36000;
		end else begin
			az_wrap = az_diff;
		end
		ax_w = 17'(axis_angle);
		if (ax_w >= 17'sd18000) begin
			ax_w = ax_w - 17'sd36000;
		end else if (ax_w < -17'sd18000) begin
			ax_w = ax_w + 17'sd36000;
		end
		ax_f = ax_w;
		ax_flip = 1'b0;
		if (ax_w > 17'sd9000) begin
			ax_f = ax_w - 17'sd18000;
			ax_flip = 1'b1;
		end else if (ax_w < -17'sd9000) begin
			ax_f = ax_w + 17'sd18000;
			ax_flip = 1'b1;
		end
		if (tilt_angle > TiltLimit) begin
			tl_c = TiltLimit;
		end else if (tilt_angle < -TiltLimit) begin
			tl_c = -TiltLimit;
		end else begin
			tl_c = tilt_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s1.img <= image_index;
			cs_s1.az <= az_wrap[15:0];
			cs_s1.byp <= byp;
			cs_s1.sx <= shift_x;
			cs_s1.sy <= shift_y;
			cs_s1.dmin <= defocus_min_in;
			cs_s1.dmax <= defocus_max_in;
			cs_s1.pix <= pixel_size;
			zax_s1 <= CzW'(ax_f) <<< 8;
			ztl_s1 <= CzW'(tl_c) <<< 8;
			fax_s1 <= ax_flip;
		end
	end

	// CORDIC for the axis and the tilt.
	logic cs_v;
	cs_side_t cs_out;
	logic signed [CxW-1:0] cos_ax;
	logic signed [CxW-1:0] sin_ax;
	logic signed [CxW-1:0] cos_tl;
	logic signed [CxW-1:0] sin_tl;

	tcda_cordic #(.SW($bits(cs_side_t))) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(v_s1),
		.z_axis(zax_s1),
		.z_tilt(ztl_s1),
		.flip_axis(fax_s1),
		.flip_tilt(1'b0),
		.side_in(cs_s1),
		.out_v(cs_v),
		.cos_axis(cos_ax),
		.sin_axis(sin_ax),
		.cos_tilt(cos_tl),
		.sin_tilt(sin_tl),
		.side_out(cs_out)
	);

	// Stage 22: shift projection products.
	logic v_s22;
	cs_side_t cs_s22;
	logic signed [53:0] p1_s22;
	logic signed [53:0] p2_s22;
	logic signed [CxW-1:0] ct_s22;
	logic signed [CxW-1:0] st_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s22 <= 1'b0;
		end else if (en) begin
			v_s22 <= cs_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s22 <= cs_out;
			p1_s22 <= 54'(cs_out.sx) * 54'(cos_ax);
			p2_s22 <= 54'(cs_out.sy) * 54'(sin_ax);
			ct_s22 <= (cos_tl < 1) ? 33'sd1 : cos_tl;
			st_s22 <= sin_tl;
		end
	end

	// Stage 23: projected shift and tangent dividend.
	logic v_s23;
	d1_side_t d1_s23;
	logic [Div1Nw-1:0] num1_s23;
	logic [Div1Dw-1:0] den1_s23;
	logic signed [54:0] xf_full;
	logic signed [CxW-1:0] st_abs;

	assign xf_full = (55'(p1_s22) + 55'(p2_s22) + 55'sd2097152) >>> 22;
	assign st_abs = (st_s22 < 0) ? -st_s22 : st_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s23 <= 1'b0;
		end else if (en) begin
			v_s23 <= v_s22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s23.img <= cs_s22.img;
			d1_s23.az <= cs_s22.az;
			d1_s23.byp <= cs_s22.byp;
			d1_s23.xf <= 31'(xf_full);
			d1_s23.neg <= st_s22[CxW-1];
			d1_s23.dmin <= cs_s22.dmin;
			d1_s23.dmax <= cs_s22.dmax;
			d1_s23.pix <= cs_s22.pix;
			num1_s23 <= (Div1Nw'(unsigned'(st_abs)) << 20)
				+ Div1Nw'(unsigned'(ct_s22 >>> 1));
			den1_s23 <= ct_s22[Div1Dw-1:0];
		end
	end

	logic d1_v;
	logic [Div1Qw-1:0] q1;
	d1_side_t d1_out;

	tcda_div #(.NW(Div1Nw), .DW(Div1Dw), .QW(Div1Qw), .SW($bits(d1_side_t))) u_div_tan (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(v_s23),
		.num(num1_s23),
		.den(den1_s23),
		.side_in(d1_s23),
		.out_v(d1_v),
		.quot(q1),
		.side_out(d1_out)
	);

	// Stage 24: shift times tangent.
	logic signed [26:0] tq;
	logic v_s24;
	d1_side_t d1_s24;
	logic signed [57:0] zp_s24;

	assign tq = d1_out.neg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s24 <= 1'b0;
		end else if (en) begin
			v_s24 <= d1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s24 <= d1_out;
			zp_s24 <= 58'(d1_out.xf) * 58'(tq);
		end
	end

	// Stage 25: round to 2^-16 pixel.
	logic v_s25;
	d1_side_t d1_s25;
	logic signed [41:0] z16_s25;
	logic signed [57:0] z16_full;

	assign z16_full = (zp_s24 + 58'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s25 <= 1'b0;
		end else if (en) begin
			v_s25 <= v_s24;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s25 <= d1_s24;
			z16_s25 <= 42'(z16_full);
		end
	end

	// Stage 26: partial products with the pixel size.
	logic v_s26;
	d1_side_t d1_s26;
	logic [39:0] pl_s26;
	logic signed [42:0] ph_s26;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
		end else if (en) begin
			v_s26 <= v_s25;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s26 <= d1_s25;
			pl_s26 <= 40'(z16_s25[19:0]) * 40'(d1_s25.pix);
			ph_s26 <= 43'($signed(z16_s25[41:20])) * 43'($signed({1'b0, d1_s25.pix}));
		end
	end

	// Stage 27: defocus offset and shifted sum.
	logic v_s27;
	d1_side_t d1_s27;
	logic signed [36:0] n_s27;
	logic signed [26:0] diff_s27;
	logic [26:0] sum_s27;
	logic signed [62:0] full;
	logic signed [62:0] rnd;
	logic signed [36:0] delta;
	logic [26:0] sum_c;

	assign full = (63'(ph_s26) <<< 20) + $signed({23'd0, pl_s26});
	assign rnd = (full + 63'sd134217728) >>> 28;
	assign delta = -37'(rnd);
	assign sum_c = 27'(d1_s26.dmin) + 27'(d1_s26.dmax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s27 <= 1'b0;
		end else if (en) begin
			v_s27 <= v_s26;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s27 <= d1_s26;
			sum_s27 <= sum_c;
			n_s27 <= $signed({10'd0, sum_c}) + (delta <<< 1);
			diff_s27 <= $signed({1'b0, d1_s26.dmax}) - $signed({1'b0, d1_s26.dmin});
		end
	end

	// Stage 28: partial products of the ratio numerator.
	logic v_s28;
	d1_side_t d1_s28;
	logic signed [36:0] n_s28;
	logic [26:0] sum_s28;
	logic signed [45:0] nl_s28;
	logic signed [45:0] nh_s28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s28 <= 1'b0;
		end else if (en) begin
			v_s28 <= v_s27;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s28 <= d1_s27;
			n_s28 <= n_s27;
			sum_s28 <= sum_s27;
			nl_s28 <= 46'($signed({1'b0, n_s27[17:0]})) * 46'(diff_s27);
			nh_s28 <= 46'($signed(n_s27[36:18])) * 46'(diff_s27);
		end
	end

	// Stage 29: ratio dividend.
	logic v_s29;
	d2_side_t d2_s29;
	logic [Div2Nw-1:0] num2_s29;
	logic [Div2Dw-1:0] den2_s29;
	logic signed [63:0] prod;
	logic [63:0] prod_abs;

	assign prod = (64'(nh_s28) <<< 18) + 64'(nl_s28);
	assign prod_abs = prod[63] ? unsigned'(-prod) : unsigned'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s29 <= 1'b0;
		end else if (en) begin
			v_s29 <= v_s28;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s29.img <= d1_s28.img;
			d2_s29.az <= d1_s28.az;
			d2_s29.byp <= d1_s28.byp;
			d2_s29.neg <= prod[63];
			d2_s29.dmin <= d1_s28.dmin;
			d2_s29.dmax <= d1_s28.dmax;
			d2_s29.n <= n_s28;
			num2_s29 <= prod_abs + Div2Nw'(sum_s28 >> 1);
			den2_s29 <= (sum_s28 == '0) ? Div2Dw'(1) : sum_s28;
		end
	end

	logic d2_v;
	logic [Div2Qw-1:0] q2;
	d2_side_t d2_out;

	tcda_div #(.NW(Div2Nw), .DW(Div2Dw), .QW(Div2Qw), .SW($bits(d2_side_t))) u_div_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(v_s29),
		.num(num2_s29),
		.den(den2_s29),
		.side_in(d2_s29),
		.out_v(d2_v),
		.quot(q2),
		.side_out(d2_out)
	);

	// Stage 30: split, saturate and register the result.
	logic signed [37:0] h;
	logic signed [38:0] lo_v;
	logic signed [38:0] hi_v;
	sat_t sat_lo;
	sat_t sat_hi;
	logic v_s30;
	logic [7:0] img_s30;
	logic [15:0] az_s30;
	logic [25:0] dmin_s30;
	logic [25:0] dmax_s30;
	logic sat_s30;
	logic at_limit;

	assign h = d2_out.neg ? -$signed({2'b00, q2}) : $signed({2'b00, q2});
	assign lo_v = (39'(d2_out.n) - 39'(h) + 39'sd1) >>> 1;
	assign hi_v = (39'(d2_out.n) + 39'(h) + 39'sd1) >>> 1;
	assign sat_lo = sat_df(lo_v);
	assign sat_hi = sat_df(hi_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s30 <= 1'b0;
		end else if (en) begin
			v_s30 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			img_s30 <= d2_out.img;
			az_s30 <= d2_out.az;
			if (d2_out.byp) begin
				dmin_s30 <= d2_out.dmin;
				dmax_s30 <= d2_out.dmax;
				sat_s30 <= 1'b0;
			end else begin
				dmin_s30 <= sat_lo.val;
				dmax_s30 <= sat_hi.val;
				sat_s30 <= sat_lo.clamp | sat_hi.clamp;
			end
		end
	end

	assign out_valid = v_s30;
	assign image_out = img_s30;
	assign azimuth_out = az_s30;
	assign defocus_min_out = dmin_s30;
	assign defocus_max_out = dmax_s30;
	assign saturated = sat_s30;

	assign at_limit = (defocus_min_out == '0) || (defocus_min_out == DfLimit)
		|| (defocus_max_out == '0) || (defocus_max_out == DfLimit);

	`TCDA_ASSERT_IMPL(a_az_range, clk, arst_n, out_valid, azimuth_out < TurnCd)
	`TCDA_ASSERT_IMPL(a_sat_edge, clk, arst_n, out_valid && saturated, at_limit)
	`TCDA_ASSERT_IMPL(a_stall_cause, clk, arst_n, !in_ready, out_valid)
	`TCDA_ASSERT_NEXT(a_pipe_hold, clk, arst_n, out_valid && !out_ready, $stable(v_s28) && $stable(v_s1))
endmodule
`default_nettype wire
